### design/two_way_sorted_record_merge_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the two-way record merge core
// Shared helpers for the concurrent checks placed at the end of the front and back end modules.
// ----------------------------------------------------------------------------
`ifndef TWO_WAY_SORTED_RECORD_MERGE_CORE_DEFINES_SVH
`define TWO_WAY_SORTED_RECORD_MERGE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSRM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TSRM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/tsrm_pkg.sv
// ----------------------------------------------------------------------------
// Two-way record merge package
// Types, constants and helpers shared by the merge core modules.
// ----------------------------------------------------------------------------
package tsrm_pkg;

    localparam int WORD_W     = 64;
    localparam int CFG_W      = 4;
    localparam int OUT_USER_W = 3;
    localparam int CMDQ_DEPTH = 2;

    typedef enum logic [1:0] {
        CMD_EMIT,
        CMD_ERROR,
        CMD_DONE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t kind;
        logic      src;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_push_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
        logic full;
    } cmdq_status_t;

    // Back end has finished reading a head record.
    typedef struct packed {
        logic valid;
        logic src;
    } head_release_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_COMPARE,
        ACT_EMIT_A,
        ACT_EMIT_B,
        ACT_DONE
    } action_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_APPLY,
        F_CMP_RD,
        F_CMP_EQ
    } front_state_t;

    typedef enum logic {
        B_IDLE,
        B_RUN
    } back_state_t;

    // Record length with out-of-range settings clamped to 1..max_words.
    function automatic int rec_len(input logic [CFG_W-1:0] rw, input int max_words);
        int n;
        n = int'(rw);
        if (n == 0) begin
            n = 1;
        end else if (n > max_words) begin
            n = max_words;
        end
        return n;
    endfunction

endpackage

### design/tsrm_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered, enable-held read data.
// ----------------------------------------------------------------------------
module tsrm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/tsrm_front.sv
// ----------------------------------------------------------------------------
// Merge front end
// Accepts input transactions, fills the head records, compares full heads
// and queues emit, error and done commands for the back end.
// ----------------------------------------------------------------------------
`include "two_way_sorted_record_merge_core_defines.svh"

module tsrm_front #(
    parameter int MAX_RECORD_WORDS = 8,
    parameter int FILL_W           = $clog2(MAX_RECORD_WORDS + 1),
    parameter int IDX_W            = (MAX_RECORD_WORDS > 1) ? $clog2(MAX_RECORD_WORDS) : 1
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [tsrm_pkg::WORD_W-1:0]  s_tdata,
    input  logic                         s_tuser,
    input  logic                         s_tlast,
    input  logic [FILL_W-1:0]            rec_n,
    input  tsrm_pkg::cmdq_status_t       q_status,
    output tsrm_pkg::cmd_push_t          q_push,
    input  tsrm_pkg::head_release_t      release_in,
    output logic                         wr_en,
    output logic                         wr_src,
    output logic [IDX_W-1:0]             wr_idx,
    output logic [tsrm_pkg::WORD_W-1:0]  wr_data
);

    tsrm_pkg::front_state_t state_reg, state_next;

    logic                        item_src_reg;
    logic [tsrm_pkg::WORD_W-1:0] item_word_reg;
    logic                        item_end_reg;

    logic [FILL_W-1:0] fill_a_reg, fill_b_reg;
    logic              ended_a_reg, ended_b_reg;
    logic              outst_a_reg, outst_b_reg;
    logic              halted_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;

    logic [FILL_W-1:0] cur_fill, new_fill, fill_a_upd, fill_b_upd;
    logic              cur_ended, cur_outst, ended_a_upd, ended_b_upd;
    logic              word_ok;
    logic              full_a, full_b, empty_a, empty_b;
    tsrm_pkg::action_t act;
    logic              go;
    logic              apply_fire;

    logic [tsrm_pkg::WORD_W-1:0] cmp_a_rd, cmp_b_rd;
    logic                        cmp_re;
    logic                        a_lt, a_gt, cmp_last;

    // Item application and action classification.
    always_comb begin
        cur_fill  = item_src_reg ? fill_b_reg : fill_a_reg;
        cur_ended = item_src_reg ? ended_b_reg : ended_a_reg;
        cur_outst = item_src_reg ? outst_b_reg : outst_a_reg;
        new_fill  = cur_fill;
        word_ok   = 1'b0;
        if (item_end_reg) begin
            // A partial head is thrown away when its stream ends.
            if (!cur_ended && (cur_fill < rec_n)) begin
                new_fill = '0;
            end
        end else if (!cur_ended && (cur_fill < rec_n)
                     && (cur_fill < FILL_W'(MAX_RECORD_WORDS))) begin
            word_ok  = 1'b1;
            new_fill = cur_fill + 1'b1;
        end
        fill_a_upd  = item_src_reg ? fill_a_reg : new_fill;
        fill_b_upd  = item_src_reg ? new_fill : fill_b_reg;
        ended_a_upd = ended_a_reg | (item_end_reg & ~item_src_reg);
        ended_b_upd = ended_b_reg | (item_end_reg & item_src_reg);
        full_a      = fill_a_upd >= rec_n;
        full_b      = fill_b_upd >= rec_n;
        empty_a     = ended_a_upd && !full_a;
        empty_b     = ended_b_upd && !full_b;
        if (full_a && full_b) begin
            act = tsrm_pkg::ACT_COMPARE;
        end else if (full_a && empty_b) begin
            act = tsrm_pkg::ACT_EMIT_A;
        end else if (full_b && empty_a) begin
            act = tsrm_pkg::ACT_EMIT_B;
        end else if (empty_a && empty_b) begin
            act = tsrm_pkg::ACT_DONE;
        end else begin
            act = tsrm_pkg::ACT_NONE;
        end
        // Wait while the back end still reads this stream's head, or the queue is full.
        go         = halted_reg || (!cur_outst && !q_status.full);
        apply_fire = (state_reg == tsrm_pkg::F_APPLY) && go && !halted_reg;
    end

    assign a_lt     = cmp_a_rd < cmp_b_rd;
    assign a_gt     = cmp_a_rd > cmp_b_rd;
    assign cmp_last = FILL_W'(cmp_idx_reg) == (rec_n - 1'b1);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tsrm_pkg::F_IDLE: begin
                if (s_tvalid) begin
                    state_next = tsrm_pkg::F_APPLY;
                end
            end
            tsrm_pkg::F_APPLY: begin
                if (go) begin
                    if (!halted_reg && (act == tsrm_pkg::ACT_COMPARE)) begin
                        state_next = tsrm_pkg::F_CMP_RD;
                    end else begin
                        state_next = tsrm_pkg::F_IDLE;
                    end
                end
            end
            tsrm_pkg::F_CMP_RD: begin
                state_next = tsrm_pkg::F_CMP_EQ;
            end
            tsrm_pkg::F_CMP_EQ: begin
                if (a_lt || a_gt || cmp_last) begin
                    state_next = tsrm_pkg::F_IDLE;
                end else begin
                    state_next = tsrm_pkg::F_CMP_RD;
                end
            end
            default: begin
                state_next = tsrm_pkg::F_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        s_tready       = 1'b0;
        q_push.valid   = 1'b0;
        q_push.cmd.kind = tsrm_pkg::CMD_EMIT;
        q_push.cmd.src = 1'b0;
        wr_en          = 1'b0;
        cmp_re         = 1'b0;
        case (state_reg)
            tsrm_pkg::F_IDLE: begin
                s_tready = 1'b1;
            end
            tsrm_pkg::F_APPLY: begin
                wr_en = apply_fire && word_ok;
                if (apply_fire) begin
                    case (act)
                        tsrm_pkg::ACT_EMIT_A: begin
                            q_push.valid = 1'b1;
                        end
                        tsrm_pkg::ACT_EMIT_B: begin
                            q_push.valid   = 1'b1;
                            q_push.cmd.src = 1'b1;
                        end
                        tsrm_pkg::ACT_DONE: begin
                            q_push.valid    = 1'b1;
                            q_push.cmd.kind = tsrm_pkg::CMD_DONE;
                        end
                        default: begin
                            q_push.valid = 1'b0;
                        end
                    endcase
                end
            end
            tsrm_pkg::F_CMP_RD: begin
                cmp_re = 1'b1;
            end
            tsrm_pkg::F_CMP_EQ: begin
                if (a_lt || a_gt) begin
                    q_push.valid   = 1'b1;
                    q_push.cmd.src = a_gt;
                end else if (cmp_last) begin
                    q_push.valid    = 1'b1;
                    q_push.cmd.kind = tsrm_pkg::CMD_ERROR;
                end
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign wr_src  = item_src_reg;
    assign wr_idx  = cur_fill[IDX_W-1:0];
    assign wr_data = item_word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tsrm_pkg::F_IDLE;
            fill_a_reg  <= '0;
            fill_b_reg  <= '0;
            ended_a_reg <= 1'b0;
            ended_b_reg <= 1'b0;
            outst_a_reg <= 1'b0;
            outst_b_reg <= 1'b0;
            halted_reg  <= 1'b0;
            cmp_idx_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (release_in.valid) begin
                if (release_in.src) begin
                    outst_b_reg <= 1'b0;
                end else begin
                    outst_a_reg <= 1'b0;
                end
            end
            if (apply_fire) begin
                fill_a_reg  <= fill_a_upd;
                fill_b_reg  <= fill_b_upd;
                ended_a_reg <= ended_a_upd;
                ended_b_reg <= ended_b_upd;
                cmp_idx_reg <= '0;
                case (act)
                    tsrm_pkg::ACT_EMIT_A: begin
                        fill_a_reg  <= '0;
                        outst_a_reg <= 1'b1;
                    end
                    tsrm_pkg::ACT_EMIT_B: begin
                        fill_b_reg  <= '0;
                        outst_b_reg <= 1'b1;
                    end
                    tsrm_pkg::ACT_DONE: begin
                        halted_reg <= 1'b1;
                    end
                    default: begin
                        halted_reg <= halted_reg;
                    end
                endcase
            end
            if (state_reg == tsrm_pkg::F_CMP_EQ) begin
                if (a_lt) begin
                    fill_a_reg  <= '0;
                    outst_a_reg <= 1'b1;
                end else if (a_gt) begin
                    fill_b_reg  <= '0;
                    outst_b_reg <= 1'b1;
                end else if (cmp_last) begin
                    halted_reg <= 1'b1;
                end else begin
                    cmp_idx_reg <= cmp_idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_src_reg  <= s_tuser;
            item_word_reg <= s_tdata;
            item_end_reg  <= s_tlast;
        end
    end

    // Copies of the heads used for the comparison only.
    tsrm_ram #(.WIDTH(tsrm_pkg::WORD_W), .DEPTH(MAX_RECORD_WORDS)) u_cmp_ram_a (
        .aclk  (aclk),
        .we    (wr_en && !wr_src),
        .waddr (wr_idx),
        .wdata (wr_data),
        .re    (cmp_re),
        .raddr (cmp_idx_reg),
        .rdata (cmp_a_rd)
    );

    tsrm_ram #(.WIDTH(tsrm_pkg::WORD_W), .DEPTH(MAX_RECORD_WORDS)) u_cmp_ram_b (
        .aclk  (aclk),
        .we    (wr_en && wr_src),
        .waddr (wr_idx),
        .wdata (wr_data),
        .re    (cmp_re),
        .raddr (cmp_idx_reg),
        .rdata (cmp_b_rd)
    );

    `TSRM_ASSERT_NOW(a_no_write_busy_head, aclk, aresetn,
        wr_en, !(wr_src ? outst_b_reg : outst_a_reg),
        "head written while the back end still reads it")

    `TSRM_ASSERT_NOW(a_no_push_when_full, aclk, aresetn,
        q_push.valid, !q_status.full,
        "command pushed into a full queue")

endmodule

### design/tsrm_cmdq.sv
// ----------------------------------------------------------------------------
// Merge command queue
// Short FIFO of commands from the front end to the back end.
// ----------------------------------------------------------------------------
module tsrm_cmdq (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  tsrm_pkg::cmd_push_t    push,
    input  logic                   pop,
    output tsrm_pkg::cmdq_status_t status
);

    localparam int AW = (tsrm_pkg::CMDQ_DEPTH > 1) ? $clog2(tsrm_pkg::CMDQ_DEPTH) : 1;
    localparam int CW = $clog2(tsrm_pkg::CMDQ_DEPTH + 1);

    tsrm_pkg::cmd_t entry_reg [tsrm_pkg::CMDQ_DEPTH];
    logic [AW-1:0]  wptr_reg, rptr_reg;
    logic [CW-1:0]  count_reg;
    logic           do_push, do_pop;

    assign do_push = push.valid && (count_reg != CW'(tsrm_pkg::CMDQ_DEPTH));
    assign do_pop  = pop && (count_reg != '0);

    assign status.valid = count_reg != '0;
    assign status.cmd   = entry_reg[rptr_reg];
    assign status.full  = count_reg == CW'(tsrm_pkg::CMDQ_DEPTH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (do_push) begin
                wptr_reg <= (wptr_reg == AW'(tsrm_pkg::CMDQ_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (do_pop) begin
                rptr_reg <= (rptr_reg == AW'(tsrm_pkg::CMDQ_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wptr_reg] <= push.cmd;
        end
    end

endmodule

### design/tsrm_back.sv
// ----------------------------------------------------------------------------
// Merge back end
// Carries out queued commands: streams a head record word by word, or
// gives the error or done result, through a read stage and output register.
// ----------------------------------------------------------------------------
`include "two_way_sorted_record_merge_core_defines.svh"

module tsrm_back #(
    parameter int MAX_RECORD_WORDS = 8,
    parameter int FILL_W           = $clog2(MAX_RECORD_WORDS + 1),
    parameter int IDX_W            = (MAX_RECORD_WORDS > 1) ? $clog2(MAX_RECORD_WORDS) : 1
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [FILL_W-1:0]                   rec_n,
    input  tsrm_pkg::cmdq_status_t              q_status,
    output logic                                q_pop,
    output tsrm_pkg::head_release_t             release_out,
    input  logic                                wr_en,
    input  logic                                wr_src,
    input  logic [IDX_W-1:0]                    wr_idx,
    input  logic [tsrm_pkg::WORD_W-1:0]         wr_data,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tsrm_pkg::WORD_W-1:0]         m_tdata,
    output logic [tsrm_pkg::OUT_USER_W-1:0]     m_tuser,
    output logic                                m_tlast
);

    tsrm_pkg::back_state_t state_reg, state_next;

    tsrm_pkg::cmd_t   cur_reg;
    logic [IDX_W-1:0] idx_reg;

    logic               rd_pending_reg;
    tsrm_pkg::cmd_kind_t rd_kind_reg;
    logic               rd_src_reg;
    logic               rd_last_reg;

    logic                        out_valid_reg;
    logic [tsrm_pkg::WORD_W-1:0] out_word_reg;
    logic                        out_src_reg, out_last_reg, out_dup_reg, out_done_reg;

    logic                        advance, can_issue, issue, last_now, emit_re;
    logic [tsrm_pkg::WORD_W-1:0] rd_a, rd_b, rd_word;

    assign advance   = rd_pending_reg && (!out_valid_reg || m_tready);
    assign can_issue = !rd_pending_reg || advance;
    assign last_now  = (cur_reg.kind != tsrm_pkg::CMD_EMIT)
                       || (FILL_W'(idx_reg) == (rec_n - 1'b1));

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tsrm_pkg::B_IDLE: begin
                if (q_status.valid) begin
                    state_next = tsrm_pkg::B_RUN;
                end
            end
            tsrm_pkg::B_RUN: begin
                if (can_issue && last_now) begin
                    state_next = tsrm_pkg::B_IDLE;
                end
            end
            default: begin
                state_next = tsrm_pkg::B_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        q_pop             = 1'b0;
        issue             = 1'b0;
        release_out.valid = 1'b0;
        release_out.src   = cur_reg.src;
        case (state_reg)
            tsrm_pkg::B_IDLE: begin
                q_pop = q_status.valid;
            end
            tsrm_pkg::B_RUN: begin
                issue = can_issue;
                // The head is free for refilling once its last word is read.
                release_out.valid = can_issue && last_now
                                    && (cur_reg.kind == tsrm_pkg::CMD_EMIT);
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
        emit_re = issue && (cur_reg.kind == tsrm_pkg::CMD_EMIT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= tsrm_pkg::B_IDLE;
            rd_pending_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (issue) begin
                rd_pending_reg <= 1'b1;
            end else if (advance) begin
                rd_pending_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_status.cmd;
            idx_reg <= '0;
        end else if (issue) begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (issue) begin
            rd_kind_reg <= cur_reg.kind;
            rd_src_reg  <= cur_reg.src;
            rd_last_reg <= last_now;
        end
        if (advance) begin
            out_word_reg <= rd_word;
            out_src_reg  <= (rd_kind_reg == tsrm_pkg::CMD_EMIT) ? rd_src_reg : 1'b0;
            out_last_reg <= rd_last_reg;
            out_dup_reg  <= rd_kind_reg == tsrm_pkg::CMD_ERROR;
            out_done_reg <= rd_kind_reg == tsrm_pkg::CMD_DONE;
        end
    end

    assign rd_word = (rd_kind_reg != tsrm_pkg::CMD_EMIT) ? '0 : (rd_src_reg ? rd_b : rd_a);

    // Copies of the heads used for emission only.
    tsrm_ram #(.WIDTH(tsrm_pkg::WORD_W), .DEPTH(MAX_RECORD_WORDS)) u_emit_ram_a (
        .aclk  (aclk),
        .we    (wr_en && !wr_src),
        .waddr (wr_idx),
        .wdata (wr_data),
        .re    (emit_re && !cur_reg.src),
        .raddr (idx_reg),
        .rdata (rd_a)
    );

    tsrm_ram #(.WIDTH(tsrm_pkg::WORD_W), .DEPTH(MAX_RECORD_WORDS)) u_emit_ram_b (
        .aclk  (aclk),
        .we    (wr_en && wr_src),
        .waddr (wr_idx),
        .wdata (wr_data),
        .re    (emit_re && cur_reg.src),
        .raddr (idx_reg),
        .rdata (rd_b)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_word_reg;
    assign m_tuser  = {out_done_reg, out_dup_reg, out_src_reg};
    assign m_tlast  = out_last_reg;

    `TSRM_ASSERT_NOW(a_final_result_alone, aclk, aresetn,
        out_valid_reg && (out_dup_reg || out_done_reg), !q_status.valid,
        "command queued behind an error or done result")

    `TSRM_ASSERT_NEXT(a_read_stage_holds, aclk, aresetn,
        rd_pending_reg && !advance, rd_pending_reg && $stable(rd_src_reg),
        "stalled read stage lost its word")

endmodule

### design/two_way_sorted_record_merge_core.sv
// ----------------------------------------------------------------------------
// Two-way sorted record merge core
// Merges two ascending streams of fixed-length records into one ascending
// stream, with duplicate detection and an end-of-merge result.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake          Contents
//  s_       in   s_tvalid/s_tready  word for stream A or B, or end of stream
//  m_       out  m_tvalid/m_tready  record word, error or done result
//  cfg_     in   cfg_we             record length in words
//
//  An input transaction is taken in the idle state and applied in the apply state.
//  A head comparison handles each compared word in turn: one RAM read, then one compare.
//  A record leaves at one word per cycle while m_tready stays high, after the back end pops its command.
//  Reset is synchronous and active low; the head RAMs need no clearing.
//  A transaction for a stream whose head is still being sent waits in the front end.
// ----------------------------------------------------------------------------
module two_way_sorted_record_merge_core #(
    parameter int MAX_RECORD_WORDS = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [tsrm_pkg::CFG_W-1:0]        cfg_wdata,   // record_words
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tsrm_pkg::WORD_W-1:0]       s_tdata,     // data_word
    input  logic                              s_tuser,     // source
    input  logic                              s_tlast,     // stream_end
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tsrm_pkg::WORD_W-1:0]       m_tdata,     // out_word
    output logic [tsrm_pkg::OUT_USER_W-1:0]   m_tuser,     // out_source, dup_error, merge_done
    output logic                              m_tlast      // out_last
);

    localparam int FILL_W = $clog2(MAX_RECORD_WORDS + 1);
    localparam int IDX_W  = (MAX_RECORD_WORDS > 1) ? $clog2(MAX_RECORD_WORDS) : 1;

    logic [tsrm_pkg::CFG_W-1:0]  record_words_reg;
    logic [FILL_W-1:0]           rec_n;

    tsrm_pkg::cmd_push_t         q_push;
    tsrm_pkg::cmdq_status_t      q_status;
    logic                        q_pop;
    tsrm_pkg::head_release_t     head_release;

    logic                        wr_en, wr_src;
    logic [IDX_W-1:0]            wr_idx;
    logic [tsrm_pkg::WORD_W-1:0] wr_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            record_words_reg <= tsrm_pkg::CFG_W'(1);
        end else if (cfg_we) begin
            record_words_reg <= cfg_wdata;
        end
    end

    assign rec_n = FILL_W'(tsrm_pkg::rec_len(record_words_reg, MAX_RECORD_WORDS));

    tsrm_front #(.MAX_RECORD_WORDS(MAX_RECORD_WORDS)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .rec_n      (rec_n),
        .q_status   (q_status),
        .q_push     (q_push),
        .release_in (head_release),
        .wr_en      (wr_en),
        .wr_src     (wr_src),
        .wr_idx     (wr_idx),
        .wr_data    (wr_data)
    );

    tsrm_cmdq u_cmdq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .pop     (q_pop),
        .status  (q_status)
    );

    tsrm_back #(.MAX_RECORD_WORDS(MAX_RECORD_WORDS)) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .rec_n       (rec_n),
        .q_status    (q_status),
        .q_pop       (q_pop),
        .release_out (head_release),
        .wr_en       (wr_en),
        .wr_src      (wr_src),
        .wr_idx      (wr_idx),
        .wr_data     (wr_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

### tb/two_way_sorted_record_merge_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the two-way sorted record merge core
// Drives words and end markers for streams A and B, keeps its own model of the
// two head records and checks every output beat in order against it. The run
// walks through several record lengths and idling patterns, then closes the
// streams and ends either on a duplicate head pair or on the end-of-merge beat.
// ----------------------------------------------------------------------------
module two_way_sorted_record_merge_core_tb;

    localparam int MAX_WORDS   = 8;
    localparam int WORD_BITS   = tsrm_pkg::WORD_W;
    localparam int SETTLE      = 32;
    localparam int HOLD_CYCLES = 200;
    localparam int STALL_LIMIT = 3000;

    // Bit positions inside m_tuser.
    localparam int USER_SRC  = 0;
    localparam int USER_DUP  = 1;
    localparam int USER_DONE = 2;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic                 src;
        logic                 last;
        logic                 dup;
        logic                 done;
    } merge_beat_t;

    class merge_checker;
        logic [WORD_BITS-1:0]       head [2][MAX_WORDS];
        int unsigned                fill [2];
        bit                         ended [2];
        bit                         halted;
        logic [tsrm_pkg::CFG_W-1:0] len_reg;
        merge_beat_t                step_beats [$];
        merge_beat_t                expected_beats [$];
        int mismatches, items_accepted, beats_seen, records_seen, dup_seen, done_seen;

        function new();
            len_reg = tsrm_pkg::CFG_W'(1);
        endfunction

        function int unsigned record_len(logic [tsrm_pkg::CFG_W-1:0] v);
            if (v == 0) return 1;
            if (v > MAX_WORDS) return MAX_WORDS;
            return int'(v);
        endfunction

        function void set_length(logic [tsrm_pkg::CFG_W-1:0] v);
            len_reg = v;
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        function void emit_head(bit src, int unsigned n);
            for (int unsigned i = 0; i < n; i++) begin
                step_beats.push_back('{head[src][i], src, (i + 1 == n), 1'b0, 1'b0});
            end
            fill[src] = 0;
        endfunction

        // One accepted transaction: update the heads, then take at most one action.
        function void merge_step(bit src, logic [WORD_BITS-1:0] w, bit last);
            int unsigned n;
            bit full_a, full_b, empty_a, empty_b;
            int order;
            step_beats.delete();
            n = record_len(len_reg);
            if (halted) return;
            if (last) begin
                if (!ended[src] && fill[src] < n) fill[src] = 0;
                ended[src] = 1'b1;
            end else if (!ended[src] && fill[src] < n && fill[src] < MAX_WORDS) begin
                head[src][fill[src]] = w;
                fill[src]++;
            end
            full_a  = fill[0] >= n;
            full_b  = fill[1] >= n;
            empty_a = ended[0] && !full_a;
            empty_b = ended[1] && !full_b;
            if (full_a && full_b) begin
                order = 0;
                for (int unsigned i = 0; i < n && order == 0; i++) begin
                    if (head[0][i] < head[1][i]) order = -1;
                    else if (head[0][i] > head[1][i]) order = 1;
                end
                if (order == 0) begin
                    halted = 1'b1;
                    step_beats.push_back('{'0, 1'b0, 1'b1, 1'b1, 1'b0});
                end else begin
                    emit_head(order > 0, n);
                end
            end else if (full_a && empty_b) begin
                emit_head(1'b0, n);
            end else if (full_b && empty_a) begin
                emit_head(1'b1, n);
            end else if (empty_a && empty_b) begin
                halted = 1'b1;
                step_beats.push_back('{'0, 1'b0, 1'b1, 1'b0, 1'b1});
            end
        endfunction

        function void note_item(bit src, logic [WORD_BITS-1:0] w, bit last);
            items_accepted++;
            merge_step(src, w, last);
            foreach (step_beats[i]) expected_beats.push_back(step_beats[i]);
        endfunction

        // Tries a transaction on a copy of the state: would it stop the merge on equal heads?
        function bit would_collide(bit src, logic [WORD_BITS-1:0] w);
            logic [WORD_BITS-1:0] head_keep [2][MAX_WORDS];
            int unsigned fill_keep [2];
            bit ended_keep [2];
            bit halted_keep;
            bit hit;
            head_keep   = head;
            fill_keep   = fill;
            ended_keep  = ended;
            halted_keep = halted;
            merge_step(src, w, 1'b0);
            hit = step_beats.size() != 0 && step_beats[0].dup;
            head   = head_keep;
            fill   = fill_keep;
            ended  = ended_keep;
            halted = halted_keep;
            step_beats.delete();
            return hit;
        endfunction

        // A shorter record can leave both heads full and equal at once.
        function bit length_would_collide(logic [tsrm_pkg::CFG_W-1:0] v);
            int unsigned n;
            n = record_len(v);
            if (fill[0] < n || fill[1] < n) return 1'b0;
            for (int unsigned i = 0; i < n; i++) begin
                if (head[0][i] != head[1][i]) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void report(string what, merge_beat_t got, merge_beat_t want);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%s: expected word %h src %0d last %0d dup %0d done %0d", what,
                         want.word, want.src, want.last, want.dup, want.done);
                $display("    got word %h src %0d last %0d dup %0d done %0d",
                         got.word, got.src, got.last, got.dup, got.done);
            end
        endfunction

        function void check_beat(logic [WORD_BITS-1:0] w, logic [tsrm_pkg::OUT_USER_W-1:0] user,
                                 logic last);
            merge_beat_t got, want;
            got = '{w, user[USER_SRC], last, user[USER_DUP], user[USER_DONE]};
            beats_seen++;
            if (got.done) done_seen++;
            else if (got.dup) dup_seen++;
            else if (got.last) records_seen++;
            if (expected_beats.size() == 0) begin
                report("Unexpected output beat", got, '0);
                return;
            end
            want = expected_beats.pop_front();
            if (got !== want) report("Output beat differs", got, want);
        endfunction
    endclass

    logic                               aclk      = 1'b0;
    logic                               aresetn   = 1'b0;
    logic                               cfg_we    = 1'b0;
    logic [tsrm_pkg::CFG_W-1:0]         cfg_wdata = '0;
    logic                               s_tvalid  = 1'b0;
    logic                               s_tready;
    logic [WORD_BITS-1:0]               s_tdata   = '0;    // data_word
    logic                               s_tuser   = 1'b0;  // source
    logic                               s_tlast   = 1'b0;  // stream_end
    logic                               m_tvalid;
    logic                               m_tready  = 1'b0;
    logic [WORD_BITS-1:0]               m_tdata;           // out_word
    logic [tsrm_pkg::OUT_USER_W-1:0]    m_tuser;           // out_source, dup_error, merge_done
    logic                               m_tlast;           // out_last

    merge_checker sb = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req       = 1'b0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    two_way_sorted_record_merge_core #(
        .MAX_RECORD_WORDS(MAX_WORDS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_beat(m_tdata, m_tuser, m_tlast);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver: random back-pressure, or a long hold-off when one is requested.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    function automatic logic [WORD_BITS-1:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // Many small values, so that heads often tie on their leading words.
    function automatic logic [WORD_BITS-1:0] key_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return WORD_BITS'($urandom_range(0, 3));
            default: return rand_word();
        endcase
    endfunction

    function automatic logic [WORD_BITS-1:0] safe_word(bit src, logic [WORD_BITS-1:0] w);
        while (sb.would_collide(src, w)) w = rand_word();
        return w;
    endfunction

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER:   begin send_idle_pct = 58; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 58; end
            IDLE_BOTH:     begin send_idle_pct = 6;  recv_stall_pct = 6;  end
            default:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    task automatic send_item(input bit src, input logic [WORD_BITS-1:0] w, input bit last);
        int gap;
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            gap = $urandom_range(1, 6);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        s_tuser  <= src;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sb.note_item(src, w, last);
    endtask

    // Waits until every expected beat is out and the front end has gone quiet.
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_length(input logic [tsrm_pkg::CFG_W-1:0] v);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        sb.set_length(v);
    endtask

    task automatic directed_checks();
        send_item(1'b0, '0, 1'b0);
        send_item(1'b1, '1, 1'b0);
        send_item(1'b1, 64'h1, 1'b0);                    // B head already full: dropped
        send_item(1'b0, 64'h8000_0000_0000_0000, 1'b0);
        send_item(1'b0, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
        drain();
        write_length(4'd0);                              // a zero length behaves as one word
        send_item(1'b0, 64'h1, 1'b0);
        drain();
        write_length(4'd3);                              // B keeps its one word and needs two more
        send_item(1'b1, 64'd5, 1'b0);
        send_item(1'b1, 64'd6, 1'b0);
        send_item(1'b0, 64'd5, 1'b0);
        send_item(1'b0, 64'd7, 1'b0);
        send_item(1'b0, 64'd9, 1'b0);
        send_item(1'b0, '1, 1'b0);
        send_item(1'b0, 64'd5, 1'b0);
        send_item(1'b0, 64'd7, 1'b0);                    // ties up to the last word, B goes first
        send_item(1'b0, 64'd3, 1'b0);
        drain();
        write_length(4'd2);                              // A now holds more words than a record
        send_item(1'b1, '1, 1'b0);
        send_item(1'b1, 64'd4, 1'b0);
    endtask

    // Words go mostly to a head that still has room, so records keep completing.
    task automatic random_traffic(input int count);
        int unsigned n;
        bit src;
        repeat (count) begin
            n = sb.record_len(sb.len_reg);
            if (sb.fill[0] >= n && sb.fill[1] < n) src = ($urandom_range(0, 99) < 85);
            else if (sb.fill[1] >= n && sb.fill[0] < n) src = ($urandom_range(0, 99) >= 85);
            else src = ($urandom_range(0, 1) == 1);
            send_item(src, safe_word(src, key_word()), 1'b0);
        end
    endtask

    task automatic end_streams(input bit try_dup);
        int unsigned n;
        n = sb.record_len(sb.len_reg);
        if (try_dup) begin
            // Close A with a full head, then feed B a copy of it.
            while (sb.fill[0] < n) send_item(1'b0, safe_word(1'b0, key_word()), 1'b0);
            send_item(1'b0, rand_word(), 1'b1);
            send_item(1'b0, rand_word(), 1'b0);
            while (!sb.halted && sb.fill[0] >= n) begin
                send_item(1'b1, sb.head[0][sb.fill[1]], 1'b0);
            end
        end
        if (!sb.halted) begin
            if (!sb.ended[0]) begin
                // The partial record left in A is thrown away by the end marker.
                while (sb.fill[0] + 1 < n) send_item(1'b0, key_word(), 1'b0);
                send_item(1'b0, rand_word(), 1'b1);
            end
            send_item(1'b0, rand_word(), 1'b1);
            send_item(1'b0, rand_word(), 1'b0);
            repeat (3 * n) send_item(1'b1, safe_word(1'b1, key_word()), 1'b0);
            if (sb.fill[1] + 1 < n) send_item(1'b1, safe_word(1'b1, key_word()), 1'b0);
            // Repeated end markers push out any record still waiting and then the done beat.
            repeat (3) send_item(1'b1, rand_word(), 1'b1);
        end
        send_item(1'b0, rand_word(), 1'b0);
        send_item(1'b1, rand_word(), 1'b1);
    endtask

    initial begin
        logic [tsrm_pkg::CFG_W-1:0] phase_len [8];
        idle_mode_t phase_mode [8];
        int phase_items [8];
        logic [tsrm_pkg::CFG_W-1:0] len_value;
        bit try_dup;
        phase_len   = '{4'd15, 4'd1, 4'd4, 4'd0, 4'd8, 4'd2, 4'd9, 4'd5};
        phase_mode  = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
                        IDLE_SENDER, IDLE_RECEIVER, IDLE_NONE, IDLE_BOTH};
        phase_items = '{35, 35, 35, 35, 35, 35, 30, 30};
        try_dup     = ($urandom_range(0, 1) == 0);

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        set_idling(IDLE_NONE);
        directed_checks();

        for (int p = 0; p < 8; p++) begin
            drain();
            len_value = phase_len[p];
            if (sb.length_would_collide(len_value)) len_value = tsrm_pkg::CFG_W'(MAX_WORDS);
            write_length(len_value);
            set_idling(phase_mode[p]);
            // The first phase holds the output back long enough to fill the core.
            if (p == 0) hold_req = 1'b1;
            random_traffic(phase_items[p]);
        end

        drain();
        set_idling(IDLE_BOTH);
        end_streams(try_dup);
        drain();

        $display("Merged %0d input transactions into %0d output beats, %0d complete records.",
                 sb.items_accepted, sb.beats_seen, sb.records_seen);
        $display("Record lengths 1 to %0d words; duplicate stops %0d, end-of-merge beats %0d.",
                 MAX_WORDS, sb.dup_seen, sb.done_seen);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
